// ===== sv/abc_pkg.sv =====
// shared widths, register indexes and constants of the audio bitcrusher
package abc_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CHANNELS_DEF = 2;
    localparam int QSTEP_W      = 15;
    localparam int HOLD_W       = 7;
    localparam int MIX_W        = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TUSER_W    = 2;
    localparam int STEP_BITS    = 16;
    localparam int ACC_W        = 34;

    localparam logic [CFG_ADDR_W-1:0] REG_QUANT_STEP  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_LENGTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NOISE_MIX   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WET_MIX     = 2'd3;

    localparam logic [QSTEP_W-1:0] QSTEP_RESET = 15'd1;
    localparam logic [MIX_W-1:0]   ONE_Q15     = 16'h8000;
    localparam logic [15:0]        LFSR_MASK   = 16'hB400;
    localparam logic [15:0]        LFSR_SEED   = 16'hACE1;

endpackage

// ===== sv/audio_bitcrusher.sv =====
// audio bitcrusher top level: sample hold, quantizer, noise and wet/dry mix, bit-serial
// one item at a time: a new item is taken only in idle, after four 16-step bit-serial
// passes (remainder, noise product, two mixes) and the handover to the output register
// the next item is taken while a finished result waits in the output register
// reset: aresetn synchronous active low, clears hold state, loads the noise seed and the
// config reset values, and resets state and output valid; datapath registers are not reset
module audio_bitcrusher #(
    parameter int CHANNELS = abc_pkg::CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [abc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [abc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // in_sample
    input  logic [abc_pkg::SAMPLE_BITS-1:0] s_axis_tdata,
    // in_channel, block_start
    input  logic [abc_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_sample
    output logic [abc_pkg::SAMPLE_BITS-1:0] m_axis_tdata,
    // out_channel
    output logic                            m_axis_tuser
);
    import abc_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BC_W = $clog2(STEP_BITS);
    localparam int DQ_W = ACC_W - 15;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV  = 4'd1;
    localparam logic [3:0] ST_QSET = 4'd2;
    localparam logic [3:0] ST_NMUL = 4'd3;
    localparam logic [3:0] ST_NSET = 4'd4;
    localparam logic [3:0] ST_MIX1 = 4'd5;
    localparam logic [3:0] ST_MSET = 4'd6;
    localparam logic [3:0] ST_MIX2 = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    localparam logic signed [DQ_W-1:0] CLIP_HI = DQ_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [DQ_W-1:0] CLIP_LO = -DQ_W'(1 << (SAMPLE_BITS - 1));

    logic [QSTEP_W-1:0] quant_step_reg;
    logic [HOLD_W-1:0]  hold_length_reg;
    logic [MIX_W-1:0]   noise_mix_reg;
    logic [MIX_W-1:0]   wet_mix_reg;

    logic [HOLD_W-1:0]             hold_cnt_reg  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] held_reg      [CHANNELS];
    logic [15:0]                   lfsr_reg,      lfsr_next;

    logic [3:0]                    state_reg,     state_next;
    logic [BC_W-1:0]               bit_cnt_reg,   bit_cnt_next;
    logic [MIX_W-1:0]              fw_reg,        fw_next;
    logic [MIX_W-1:0]              gw_reg,        gw_next;
    logic [SAMPLE_BITS-1:0]        mag_reg,       mag_next;
    logic [SAMPLE_BITS-1:0]        rem_reg,       rem_next;
    logic                          neg_reg,       neg_next;
    logic signed [SAMPLE_BITS-1:0] q_reg,         q_next;
    logic signed [SAMPLE_BITS-1:0] a_reg,         a_next;
    logic signed [SAMPLE_BITS-1:0] b_reg,         b_next;
    logic signed [SAMPLE_BITS-1:0] x_reg,         x_next;
    logic                          chan_reg,      chan_next;
    logic signed [ACC_W-1:0]       acc_reg,       acc_next;
    logic                          out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]        out_data_reg,  out_data_next;
    logic                          out_chan_reg,  out_chan_next;

    logic                          in_take;
    logic [CH_W-1:0]               ch_sel;
    logic [HOLD_W-1:0]             hold_len_eff;
    logic [HOLD_W-1:0]             cnt_eff;
    logic                          run_start;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [SAMPLE_BITS-1:0] cur;
    logic [QSTEP_W-1:0]            step_eff;
    logic [SAMPLE_BITS:0]          rem_sh;
    logic [SAMPLE_BITS-1:0]        qmag;
    logic [SAMPLE_BITS-1:0]        n_mag;
    logic [MIX_W-1:0]              noise_fw;
    logic [MIX_W-1:0]              wet_fw;
    logic signed [ACC_W-1:0]       acc_bias;
    logic signed [DQ_W-1:0]        acc_q15;
    logic signed [SAMPLE_BITS-1:0] y_clip;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_chan_reg;

    // hold control for the channel of the incoming item
    always_comb begin
        if ({31'b0, s_axis_tuser[0]} < CHANNELS) begin
            ch_sel = CH_W'(s_axis_tuser[0]);
        end else begin
            ch_sel = CH_W'(CHANNELS - 1);
        end
        hold_len_eff = (hold_length_reg == '0) ? HOLD_W'(1) : hold_length_reg;
        if (s_axis_tuser[1] || (hold_cnt_reg[ch_sel] >= hold_len_eff)) begin
            cnt_eff = '0;
        end else begin
            cnt_eff = hold_cnt_reg[ch_sel];
        end
        run_start = (cnt_eff == '0);
        x_in      = s_axis_tdata;
        cur       = run_start ? x_in : held_reg[ch_sel];
    end

    assign step_eff = (quant_step_reg == '0) ? QSTEP_W'(1) : quant_step_reg;
    assign rem_sh   = {rem_reg, fw_reg[MIX_W-1]};
    assign qmag     = mag_reg - rem_reg;
    assign n_mag    = acc_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign noise_fw = noise_mix_reg[MIX_W-1] ? ONE_Q15 : noise_mix_reg;
    assign wet_fw   = wet_mix_reg[MIX_W-1] ? ONE_Q15 : wet_mix_reg;

    // divide by 32768 toward zero, then clip
    always_comb begin
        acc_bias = acc_reg[ACC_W-1] ? ACC_W'(32767) : '0;
        acc_q15  = DQ_W'((acc_reg + acc_bias) >>> 15);
        if (acc_q15 > CLIP_HI) begin
            y_clip = SAMPLE_BITS'(CLIP_HI);
        end else if (acc_q15 < CLIP_LO) begin
            y_clip = SAMPLE_BITS'(CLIP_LO);
        end else begin
            y_clip = SAMPLE_BITS'(acc_q15);
        end
    end

    always_comb begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        fw_next        = fw_reg;
        gw_next        = gw_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        chan_next      = chan_reg;
        acc_next       = acc_reg;
        lfsr_next      = lfsr_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_chan_next  = out_chan_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    x_next       = x_in;
                    chan_next    = s_axis_tuser[0];
                    neg_next     = cur[SAMPLE_BITS-1];
                    mag_next     = cur[SAMPLE_BITS-1] ? -cur : cur;
                    fw_next      = cur[SAMPLE_BITS-1] ? -cur : cur;
                    rem_next     = '0;
                    bit_cnt_next = BC_W'(STEP_BITS - 1);
                    lfsr_next    = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK)
                                               : (lfsr_reg >> 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring remainder, one dividend bit per cycle
                if (rem_sh >= {2'b00, step_eff}) begin
                    rem_next = SAMPLE_BITS'(rem_sh - {2'b00, step_eff});
                end else begin
                    rem_next = rem_sh[SAMPLE_BITS-1:0];
                end
                fw_next      = fw_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0) begin
                    state_next = ST_QSET;
                end
            end
            ST_QSET: begin
                mag_next     = qmag;
                q_next       = neg_reg ? -qmag : qmag;
                fw_next      = lfsr_reg;
                acc_next     = '0;
                bit_cnt_next = BC_W'(STEP_BITS - 1);
                state_next   = ST_NMUL;
            end
            ST_NMUL: begin
                // |q| times the noise word, msb first
                acc_next = (acc_reg <<< 1)
                         + (fw_reg[MIX_W-1] ? {{(ACC_W-SAMPLE_BITS){1'b0}}, mag_reg}
                                            : ACC_W'(0));
                fw_next      = fw_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0) begin
                    state_next = ST_NSET;
                end
            end
            ST_NSET: begin
                a_next       = neg_reg ? -n_mag : n_mag;
                b_next       = q_reg;
                fw_next      = noise_fw;
                gw_next      = ONE_Q15 - noise_fw;
                acc_next     = '0;
                bit_cnt_next = BC_W'(STEP_BITS - 1);
                state_next   = ST_MIX1;
            end
            ST_MIX1, ST_MIX2: begin
                // a*f + b*(1-f), both weights shifted out msb first
                acc_next = (acc_reg <<< 1)
                         + (fw_reg[MIX_W-1] ? {{(ACC_W-SAMPLE_BITS){a_reg[SAMPLE_BITS-1]}},
                                               a_reg} : ACC_W'(0))
                         + (gw_reg[MIX_W-1] ? {{(ACC_W-SAMPLE_BITS){b_reg[SAMPLE_BITS-1]}},
                                               b_reg} : ACC_W'(0));
                fw_next      = fw_reg << 1;
                gw_next      = gw_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0) begin
                    state_next = (state_reg == ST_MIX1) ? ST_MSET : ST_FIN;
                end
            end
            ST_MSET: begin
                a_next       = y_clip;
                b_next       = x_reg;
                fw_next      = wet_fw;
                gw_next      = ONE_Q15 - wet_fw;
                acc_next     = '0;
                bit_cnt_next = BC_W'(STEP_BITS - 1);
                state_next   = ST_MIX2;
            end
            ST_FIN: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = y_clip;
                    out_chan_next  = chan_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            lfsr_reg        <= LFSR_SEED;
            quant_step_reg  <= QSTEP_RESET;
            hold_length_reg <= '0;
            noise_mix_reg   <= '0;
            wet_mix_reg     <= ONE_Q15;
            for (int i = 0; i < CHANNELS; i++) begin
                hold_cnt_reg[i] <= '0;
                held_reg[i]     <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lfsr_reg      <= lfsr_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_QUANT_STEP:  quant_step_reg  <= cfg_wdata[QSTEP_W-1:0];
                    REG_HOLD_LENGTH: hold_length_reg <= cfg_wdata[HOLD_W-1:0];
                    REG_NOISE_MIX:   noise_mix_reg   <= cfg_wdata[MIX_W-1:0];
                    REG_WET_MIX:     wet_mix_reg     <= cfg_wdata[MIX_W-1:0];
                    default: ;
                endcase
            end
            if (in_take) begin
                hold_cnt_reg[ch_sel] <= cnt_eff + 1'b1;
                if (run_start) begin
                    held_reg[ch_sel] <= x_in;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        bit_cnt_reg  <= bit_cnt_next;
        fw_reg       <= fw_next;
        gw_reg       <= gw_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        q_reg        <= q_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        x_reg        <= x_next;
        chan_reg     <= chan_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_chan_reg <= out_chan_next;
    end

endmodule

// ===== sv/abc_checker.sv =====
// port-level checker for the audio bitcrusher, bound to the top level
module abc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [abc_pkg::SAMPLE_BITS-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);
    import abc_pkg::*;

    // no result out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item at a time
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // no result can come out of the cycle right after an item is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

endmodule

bind audio_bitcrusher abc_checker u_abc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
